@@ sv/mgds_pkg.sv @@
`default_nettype none

package mgds_pkg;

	// operation codes of an input item
	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// cell codes
	localparam logic [1:0] CELL_CLEAN  = 2'd0;
	localparam logic [1:0] CELL_SPREAD = 2'd1;
	localparam logic [1:0] CELL_BLOCK  = 2'd2;
	localparam logic [1:0] CELL_THREE  = 2'd3;

	// register map
	localparam int          ADDR_W       = 3;
	localparam int          DATA_W       = 32;
	localparam int          AREA_W       = 5;
	localparam logic        REG_ROWS     = 1'b0;
	localparam logic        REG_COLS     = 1'b1;
	localparam logic [4:0]  ROWS_RESET   = 5'd10;
	localparam logic [4:0]  COLS_RESET   = 5'd10;

	// one item as it travels to the grid
	typedef struct packed {
		logic       fire;
		func_t      func;
		logic [3:0] row;
		logic [3:0] col;
		logic [1:0] val;
	} op_t;

	// one result item
	typedef struct packed {
		logic [1:0] cell_out;
		logic       bad_address;
	} res_t;

endpackage

`default_nettype wire

@@ sv/mgds_if.sv @@
`default_nettype none

// input channel: one operation per transfer
interface mgds_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [3:0] cell_row;
	logic [3:0] cell_col;
	logic [1:0] cell_in;

	modport source (output valid, func, cell_row, cell_col, cell_in, input ready);
	modport sink (input valid, func, cell_row, cell_col, cell_in, output ready);
endinterface

// output channel: one result per transfer
interface mgds_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] cell_out;
	logic       bad_address;

	modport source (output valid, cell_out, bad_address, input ready);
	modport sink (input valid, cell_out, bad_address, output ready);
endinterface

`default_nettype wire

@@ sv/mgds_apb_regs.sv @@
`default_nettype none

module mgds_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mgds_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mgds_pkg::DATA_W-1:0] pwdata,
	output logic      [mgds_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output logic      [mgds_pkg::AREA_W-1:0] rows_q,
	output logic      [mgds_pkg::AREA_W-1:0] cols_q
);
	import mgds_pkg::*;

	logic wr_en;
	logic reg_sel;

	// word select, byte lanes ignored
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// area registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (wr_en) begin
			if (reg_sel == REG_ROWS) begin
				rows_q <= pwdata[AREA_W-1:0];
			end else begin
				cols_q <= pwdata[AREA_W-1:0];
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_sel == REG_ROWS) begin
			prdata[AREA_W-1:0] = rows_q;
		end else begin
			prdata[AREA_W-1:0] = cols_q;
		end
	end

endmodule

`default_nettype wire

@@ sv/mgds_cell_grid.sv @@
`default_nettype none

module mgds_cell_grid #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mgds_pkg::op_t               op,
	input  wire logic [mgds_pkg::AREA_W-1:0] rows_in_use,
	input  wire logic [mgds_pkg::AREA_W-1:0] cols_in_use,
	output mgds_pkg::res_t                   res
);
	import mgds_pkg::*;

	logic [1:0] cells_q [GRID_ROWS][GRID_COLS];
	logic [1:0] cells_d [GRID_ROWS][GRID_COLS];
	logic       row_in  [GRID_ROWS];
	logic       col_in  [GRID_COLS];
	logic       hot     [GRID_ROWS][GRID_COLS];
	logic       addr_ok;
	logic       rw_op;
	logic [1:0] wr_val;
	logic [1:0] rd_val;

	// rows and columns inside the in-use area
	always_comb begin
		for (int r = 0; r < GRID_ROWS; r++) begin
			row_in[r] = r < int'(rows_in_use);
		end
		for (int c = 0; c < GRID_COLS; c++) begin
			col_in[c] = c < int'(cols_in_use);
		end
	end

	// address check against the in-use area and the grid size
	assign addr_ok = ({1'b0, op.row} < rows_in_use) && (int'(op.row) < GRID_ROWS) &&
		({1'b0, op.col} < cols_in_use) && (int'(op.col) < GRID_COLS);
	assign rw_op  = (op.func == FUNC_WRITE) || (op.func == FUNC_READ);
	assign wr_val = (op.val == CELL_THREE) ? CELL_BLOCK : op.val;

	// spread cells that may act as neighbours
	always_comb begin
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				hot[r][c] = row_in[r] && col_in[c] && (cells_q[r][c] == CELL_SPREAD);
			end
		end
	end

	// next state of every cell
	always_comb begin
		logic grow;
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				grow = hot[r][c];
				if (r > 0) begin
					grow = grow || hot[r-1][c];
				end
				if (r < GRID_ROWS - 1) begin
					grow = grow || hot[r+1][c];
				end
				if (c > 0) begin
					grow = grow || hot[r][c-1];
				end
				if (c < GRID_COLS - 1) begin
					grow = grow || hot[r][c+1];
				end
				cells_d[r][c] = cells_q[r][c];
				if (op.fire && op.func == FUNC_WRITE && addr_ok &&
						int'(op.row) == r && int'(op.col) == c) begin
					cells_d[r][c] = wr_val;
				end else if (op.fire && op.func == FUNC_TICK && row_in[r] && col_in[c] &&
						cells_q[r][c] != CELL_BLOCK && grow) begin
					cells_d[r][c] = CELL_SPREAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_ROWS; r++) begin
				for (int c = 0; c < GRID_COLS; c++) begin
					cells_q[r][c] <= CELL_CLEAN;
				end
			end
		end else begin
			cells_q <= cells_d;
		end
	end

	// read select over the grid
	always_comb begin
		rd_val = CELL_CLEAN;
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				if (int'(op.row) == r && int'(op.col) == c) begin
					rd_val = rd_val | cells_q[r][c];
				end
			end
		end
	end

	// result of the current item
	always_comb begin
		res.bad_address = rw_op && !addr_ok;
		res.cell_out    = (op.func == FUNC_READ && addr_ok) ? rd_val : CELL_CLEAN;
	end

endmodule

`default_nettype wire

@@ sv/masked_grid_dilation_step.sv @@
// Masked 4-neighbour dilation grid. Each input transfer carries a write, a read,
// a tick or a no-op, and yields exactly one result transfer. The cells sit in
// flip-flops and a tick updates all cells of the in-use area together, so while
// the result side keeps up one item is accepted every cycle. An item passes the
// input register, then the result register, which offers its result. A result
// left waiting holds the item behind it in the input register, and the input
// stalls while both registers are full and the result is not taken. Reset clears
// the whole grid at once, with no clearing pass. The in-use area is set over the
// APB port (rows at byte 0, columns at byte 4); the user must change it only while
// no item is in flight, and the block itself does not enforce this.
`default_nettype none

module masked_grid_dilation_step #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mgds_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mgds_pkg::DATA_W-1:0] pwdata,
	output logic      [mgds_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	mgds_in_if.sink                          in_ch,
	mgds_out_if.source                       out_ch
);
	import mgds_pkg::*;

	logic [AREA_W-1:0] rows_q;
	logic [AREA_W-1:0] cols_q;
	logic              valid_s1;
	op_t               op_s1;
	op_t               grid_op;
	res_t              res_comb;
	logic              out_valid_q;
	res_t              res_q;
	logic              advance;
	logic              in_take;

	mgds_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rows_q  (rows_q),
		.cols_q  (cols_q)
	);

	// pipeline control
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take     = in_ch.valid && in_ch.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1.fire <= 1'b1;
			op_s1.func <= func_t'(in_ch.func);
			op_s1.row  <= in_ch.cell_row;
			op_s1.col  <= in_ch.cell_col;
			op_s1.val  <= in_ch.cell_in;
		end
	end

	always_comb begin
		grid_op      = op_s1;
		grid_op.fire = advance;
	end

	mgds_cell_grid #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_grid (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (grid_op),
		.rows_in_use (rows_q),
		.cols_in_use (cols_q),
		.res         (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.cell_out    = res_q.cell_out;
	assign out_ch.bad_address = res_q.bad_address;

	// a flagged address never returns a cell
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bad_address |-> res_q.cell_out == CELL_CLEAN)
		else $error("flagged result carries a cell value");

	// a stored cell is never code three
	a_no_three: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.cell_out != CELL_THREE)
		else $error("result carries cell code three");

	// an item leaving the input register lands in the result register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("item lost between stages");

	// an accepted item occupies the input register
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted item not held");

endmodule

`default_nettype wire
